FILE: rtl/core/ycv_pkg.sv
// Package: shared types, constants and the CORDIC arctangent table for the camera view block.
package ycv_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int NUM_STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int STEP_W = $clog2(ATAN_ENTRIES);
   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

   localparam logic [1:0] CMD_PLACE = 2'd0;
   localparam logic [1:0] CMD_MOVE  = 2'd1;
   localparam logic [1:0] CMD_TURN  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_ROTATE,
      ST_FINISH,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_MUL_D,
      ST_MOVE_UPD,
      ST_DONE
   } state_type;

   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
      logic [31:0] tbl [ATAN_ENTRIES] = '{
         32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
         32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
         32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
         32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
         32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      return (int'(idx) < ATAN_ENTRIES) ? tbl[idx] : 32'd0;
   endfunction

   // Round a sum of Q1.14 x Q16.16 products to Q16.16 and saturate.
   function automatic logic signed [31:0] round_sat(input logic signed [49:0] v);
      logic signed [49:0] r;
      logic signed [35:0] q;
      r = v + 50'sd8192;
      q = r[49:14];
      if (q > 36'sd2147483647) return 32'sh7FFFFFFF;
      if (q < -36'sd2147483648) return 32'sh80000000;
      return q[31:0];
   endfunction

endpackage

FILE: rtl/core/yaw_camera_view_update.sv
// Top level: yaw-only camera state with CORDIC sin/cos and shared multiplier.
//
// Each command transaction (place, move, turn) updates the camera state and
// returns one view transaction: cos/sin of the heading in Q1.14 and the view
// translations in Q16.16. The block works on one transaction at a time. For a
// turn, a place or an unused code, one pass runs a prep step, the CORDIC steps
// at one per cycle, a finish step, four products through a single 16x32
// multiplier, and a write-back step. A move runs that sequence twice: first
// with the current heading to update the position, then for the view. The
// result is held until it has been taken; the block then returns to idle,
// where the next command is accepted. req_stall is high from acceptance
// until the result has been taken.
module yaw_camera_view_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_move_right,
   input  logic signed [31:0] req_move_forward,
   input  logic signed [15:0] req_turn,
   input  logic signed [31:0] req_new_x,
   input  logic signed [31:0] req_new_y,
   input  logic signed [31:0] req_new_z,
   input  logic [15:0]        req_new_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_cos_heading,
   output logic signed [15:0] rsp_sin_heading,
   output logic signed [31:0] rsp_trans_x,
   output logic signed [31:0] rsp_trans_y,
   output logic signed [31:0] rsp_trans_z
);

   ycv_pkg::state_type state_ff, state_in;

   logic signed [31:0] pos_x_ff, pos_z_ff, pos_y_ff;
   logic [15:0]        heading_ff;
   logic               move_ff;       // first pass of a move still pending
   logic signed [31:0] r_ff, f_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [33:0] cz_ff;
   logic               flip_ff;
   logic [ycv_pkg::STEP_W-1:0] step_ff;
   logic signed [15:0] c_ff, s_ff;
   logic signed [46:0] prod_ff;
   logic signed [49:0] acc_ff;
   logic signed [35:0] res_a_ff;      // first rounded sum, kept unsaturated

   logic accept;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ycv_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == ycv_pkg::ST_DONE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ycv_pkg::ST_IDLE:   if (accept) state_in = ycv_pkg::ST_PREP;
         ycv_pkg::ST_PREP:   state_in = ycv_pkg::ST_ROTATE;
         ycv_pkg::ST_ROTATE: begin
            if (int'(step_ff) == ycv_pkg::NUM_STEPS - 1) state_in = ycv_pkg::ST_FINISH;
         end
         ycv_pkg::ST_FINISH:   state_in = ycv_pkg::ST_MUL_A;
         ycv_pkg::ST_MUL_A:    state_in = ycv_pkg::ST_MUL_B;
         ycv_pkg::ST_MUL_B:    state_in = ycv_pkg::ST_MUL_C;
         ycv_pkg::ST_MUL_C:    state_in = ycv_pkg::ST_MUL_D;
         ycv_pkg::ST_MUL_D:    state_in = ycv_pkg::ST_MOVE_UPD;
         ycv_pkg::ST_MOVE_UPD: state_in = move_ff ? ycv_pkg::ST_PREP : ycv_pkg::ST_DONE;
         ycv_pkg::ST_DONE:     if (!rsp_stall) state_in = ycv_pkg::ST_IDLE;
         default:              state_in = ycv_pkg::ST_IDLE;
      endcase
   end

   // Shared multiplier operands: four products, pair summed per output.
   logic signed [15:0] mul_a;
   logic signed [31:0] mul_b;
   always_comb begin
      mul_a = c_ff;
      mul_b = pos_x_ff;
      unique case (state_ff)
         ycv_pkg::ST_MUL_A: begin
            mul_a = move_ff ? -s_ff : s_ff;
            mul_b = move_ff ? r_ff : pos_x_ff;
         end
         ycv_pkg::ST_MUL_B: begin
            mul_a = move_ff ? c_ff : -c_ff;
            mul_b = move_ff ? f_ff : pos_z_ff;
         end
         ycv_pkg::ST_MUL_C: begin
            mul_a = c_ff;
            mul_b = move_ff ? r_ff : pos_x_ff;
         end
         ycv_pkg::ST_MUL_D: begin
            mul_a = s_ff;
            mul_b = move_ff ? f_ff : pos_z_ff;
         end
         default: ;
      endcase
   end

   // CORDIC step values.
   logic signed [33:0] dx, dy;
   logic signed [32:0] atn;
   assign dx  = cy_ff >>> step_ff;
   assign dy  = cx_ff >>> step_ff;
   assign atn = $signed({1'b0, ycv_pkg::atan_turn(step_ff)});

   logic [15:0] fold;
   logic signed [17:0] cr, sr;
   logic signed [15:0] cc, sc;
   assign fold = (heading_ff >= 16'h4000 && heading_ff < 16'hC000) ?
                 (heading_ff ^ 16'h8000) : heading_ff;
   assign cr = 18'((cx_ff + 34'sd32768) >>> 16);
   assign sr = 18'((cy_ff + 34'sd32768) >>> 16);
   always_comb begin
      cc = (cr > 18'sd16384) ? 16'sd16384 : (cr < -18'sd16384) ? -16'sd16384 : cr[15:0];
      sc = (sr > 18'sd16384) ? 16'sd16384 : (sr < -18'sd16384) ? -16'sd16384 : sr[15:0];
   end

   // A move delta can exceed 32 bits; keep it whole until the position saturates.
   logic signed [49:0] sum;
   assign sum = acc_ff + 50'(prod_ff);
   logic signed [35:0] rnd;
   logic signed [36:0] nx, nz;
   logic signed [31:0] dlt;
   assign rnd = 36'((sum + 50'sd8192) >>> 14);
   assign dlt = ycv_pkg::round_sat(sum);
   assign nx = 37'(pos_x_ff) + 37'(res_a_ff);
   assign nz = 37'(pos_z_ff) + 37'(rnd);

   function automatic logic signed [31:0] sat37(input logic signed [36:0] v);
      if (v > 37'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -37'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ycv_pkg::ST_IDLE;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         pos_z_ff   <= '0;
         heading_ff <= '0;
         move_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ycv_pkg::ST_IDLE: begin
               if (accept) begin
                  // Apply place and turn now; defer move until sin/cos ready.
                  move_ff <= (req_command == ycv_pkg::CMD_MOVE);
                  r_ff    <= req_move_right;
                  f_ff    <= req_move_forward;
                  if (req_command == ycv_pkg::CMD_PLACE) begin
                     pos_x_ff   <= req_new_x;
                     pos_y_ff   <= req_new_y;
                     pos_z_ff   <= req_new_z;
                     heading_ff <= 16'(17'h10000 - 17'(req_new_angle));
                  end else if (req_command == ycv_pkg::CMD_TURN) begin
                     heading_ff <= heading_ff + req_turn;
                  end
               end
            end
            ycv_pkg::ST_PREP: begin
               flip_ff <= (heading_ff >= 16'h4000 && heading_ff < 16'hC000);
               cx_ff   <= ycv_pkg::CORDIC_START;
               cy_ff   <= '0;
               cz_ff   <= 34'($signed(fold)) <<< 16;
               step_ff <= '0;
            end
            ycv_pkg::ST_ROTATE: begin
               if (!cz_ff[33]) begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  cz_ff <= cz_ff - 34'(atn);
               end else begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  cz_ff <= cz_ff + 34'(atn);
               end
               step_ff <= step_ff + 1'b1;
            end
            ycv_pkg::ST_FINISH: begin
               c_ff   <= flip_ff ? -cc : cc;
               s_ff   <= flip_ff ? -sc : sc;
               acc_ff <= '0;
               prod_ff <= '0;
            end
            ycv_pkg::ST_MUL_A, ycv_pkg::ST_MUL_C: begin
               prod_ff <= 47'(mul_a * mul_b);
               acc_ff  <= '0;
               if (state_ff == ycv_pkg::ST_MUL_C) res_a_ff <= rnd;
            end
            ycv_pkg::ST_MUL_B, ycv_pkg::ST_MUL_D: begin
               prod_ff <= 47'(mul_a * mul_b);
               acc_ff  <= sum;
            end
            ycv_pkg::ST_MOVE_UPD: begin
               if (move_ff) begin
                  pos_x_ff <= sat37(nx);
                  pos_z_ff <= sat37(nz);
                  move_ff  <= 1'b0;
               end else begin
                  rsp_cos_heading <= c_ff;
                  rsp_sin_heading <= s_ff;
                  rsp_trans_x     <= sat37(37'(res_a_ff));
                  rsp_trans_z     <= dlt;
                  rsp_trans_y     <= (pos_y_ff == 32'sh80000000) ? 32'sh7FFFFFFF : -pos_y_ff;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

FILE: rtl/core/yaw_camera_view_update_checker.sv
// Checker: port-level properties of the camera view block, bound to the top level.
module yaw_camera_view_update_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic signed [15:0] rsp_cos_heading,
   input logic signed [15:0] rsp_sin_heading
);
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("not busy after accept");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cos_heading))
      else $error("result dropped");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accepting while result pending");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cos_heading <= 16'sd16384 && rsp_cos_heading >= -16'sd16384 &&
      rsp_sin_heading <= 16'sd16384 && rsp_sin_heading >= -16'sd16384)
      else $error("sin/cos out of range");
endmodule

bind yaw_camera_view_update yaw_camera_view_update_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_cos_heading(rsp_cos_heading), .rsp_sin_heading(rsp_sin_heading));
